@@ rtl/mssc_pkg.sv @@
// mssc_pkg: shared constants and types of the tcp mss clamp block
// no dependencies; used by mssc_walker, mssc_result and tcp_mss_clamp
`default_nettype none

package mssc_pkg;

  // configuration register indexes
  localparam logic CfgIpv4Limit = 1'b0;
  localparam logic CfgIpv6Limit = 1'b1;

  localparam int unsigned LimitW = 11;

  // tcp header constants
  localparam logic [7:0] ProtoTcp      = 8'd6;
  localparam logic [6:0] PosDataOffset = 7'd12;
  localparam logic [6:0] PosFlags      = 7'd13;
  localparam logic [6:0] PosCsumHigh   = 7'd16;
  localparam logic [6:0] PosCsumLow    = 7'd17;
  localparam logic [6:0] HdrMinLen     = 7'd20;
  localparam logic [6:0] PosMax        = 7'd127;

  // option codes
  localparam logic [7:0] OptEnd    = 8'd0;
  localparam logic [7:0] OptNop    = 8'd1;
  localparam logic [7:0] OptMss    = 8'd2;
  localparam logic [7:0] OptMssLen = 8'd4;
  localparam logic [7:0] OptMinLen = 8'd2;

  // what the header parser hands to the result stage for the current word
  typedef struct packed {
    logic        emit;
    logic        syn;
    logic [5:0]  hdr_len;
    logic [15:0] csum;
    logic [15:0] mss;
    logic [5:0]  mss_off;
  } seg_info_t;

endpackage

`default_nettype wire

@@ rtl/mssc_walker.sv @@
// mssc_walker: per-segment header parser and tcp option walker
// depends on mssc_pkg
`default_nettype none

module mssc_walker (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var logic              adv_i,
  input  var logic [7:0]        data_byte_i,
  input  var logic              last_byte_i,
  output mssc_pkg::seg_info_t   info_o
);

  typedef enum logic [2:0] {
    PhKind,
    PhLen,
    PhSkip,
    PhMssHigh,
    PhMssLow
  } phase_e;

  logic [6:0]  pos_q, pos_d;
  logic [5:0]  hl_q, hl_d;
  logic        syn_q, syn_d;
  logic [15:0] csum_q, csum_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  kind_q, kind_d;
  logic [6:0]  end_q, end_d;
  logic [15:0] mss_q, mss_d;
  logic [5:0]  off_q, off_d;
  logic        done_q, done_d;
  logic        sent_q, sent_d;

  logic        emit;
  logic [6:0]  hend;
  logic [8:0]  opt_end_full;
  logic [6:0]  pos_m1;

  assign pos_m1       = pos_q - 7'd1;
  assign opt_end_full = {2'b00, pos_q} + {1'b0, data_byte_i} - 9'd1;
  assign hend         = ({1'b0, hl_d} > mssc_pkg::HdrMinLen) ? {1'b0, hl_d}
                                                             : mssc_pkg::HdrMinLen;

  // one parse step for the current word
  always_comb begin
    hl_d    = hl_q;
    syn_d   = syn_q;
    csum_d  = csum_q;
    phase_d = phase_q;
    kind_d  = kind_q;
    end_d   = end_q;
    mss_d   = mss_q;
    off_d   = off_q;
    done_d  = done_q;
    sent_d  = sent_q;
    emit    = 1'b0;
    if (!sent_q) begin
      // fixed header fields
      if (pos_q == mssc_pkg::PosDataOffset) begin
        hl_d = {data_byte_i[7:4], 2'b00};
      end else if (pos_q == mssc_pkg::PosFlags) begin
        syn_d = data_byte_i[1];
      end else if (pos_q == mssc_pkg::PosCsumHigh) begin
        csum_d = {data_byte_i, csum_q[7:0]};
      end else if (pos_q == mssc_pkg::PosCsumLow) begin
        csum_d = {csum_q[15:8], data_byte_i};
      end

      // option walk inside the header
      if (pos_q >= mssc_pkg::HdrMinLen && pos_q < {1'b0, hl_q} && !done_q) begin
        unique case (phase_q)
          PhKind: begin
            if (data_byte_i == mssc_pkg::OptEnd) begin
              done_d = 1'b1;
            end else if (data_byte_i != mssc_pkg::OptNop) begin
              kind_d  = data_byte_i;
              phase_d = PhLen;
            end
          end
          PhLen: begin
            if (data_byte_i < mssc_pkg::OptMinLen) begin
              done_d = 1'b1;
            end else if (kind_q == mssc_pkg::OptMss) begin
              if (data_byte_i == mssc_pkg::OptMssLen) begin
                phase_d = PhMssHigh;
              end else begin
                done_d = 1'b1;
              end
            end else begin
              end_d   = (opt_end_full > {2'b00, mssc_pkg::PosMax}) ? mssc_pkg::PosMax
                                                                   : opt_end_full[6:0];
              phase_d = (data_byte_i == mssc_pkg::OptMinLen) ? PhKind : PhSkip;
            end
          end
          PhSkip: begin
            if ({1'b0, pos_q} + 8'd1 >= {1'b0, end_q}) begin
              phase_d = PhKind;
            end
          end
          PhMssHigh: begin
            kind_d  = data_byte_i;
            phase_d = PhMssLow;
          end
          PhMssLow: begin
            mss_d  = {kind_q, data_byte_i};
            off_d  = pos_m1[5:0];
            done_d = 1'b1;
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end

      // result due at header end or on a truncated segment
      emit = last_byte_i || ({1'b0, pos_q} + 8'd1 >= {1'b0, hend});
      if (emit) begin
        sent_d = 1'b1;
      end
    end
    pos_d = (pos_q == mssc_pkg::PosMax) ? pos_q : pos_q + 7'd1;
  end

  assign info_o = '{emit: emit, syn: syn_d, hdr_len: hl_d, csum: csum_d,
                    mss: mss_d, mss_off: off_d};

  // segment state, cleared after the final word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hl_q    <= '0;
      syn_q   <= 1'b0;
      csum_q  <= '0;
      phase_q <= PhKind;
      kind_q  <= '0;
      end_q   <= '0;
      mss_q   <= '0;
      off_q   <= '0;
      done_q  <= 1'b0;
      sent_q  <= 1'b0;
    end else if (adv_i) begin
      if (last_byte_i) begin
        pos_q   <= '0;
        hl_q    <= '0;
        syn_q   <= 1'b0;
        csum_q  <= '0;
        phase_q <= PhKind;
        kind_q  <= '0;
        end_q   <= '0;
        mss_q   <= '0;
        off_q   <= '0;
        done_q  <= 1'b0;
        sent_q  <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        hl_q    <= hl_d;
        syn_q   <= syn_d;
        csum_q  <= csum_d;
        phase_q <= phase_d;
        kind_q  <= kind_d;
        end_q   <= end_d;
        mss_q   <= mss_d;
        off_q   <= off_d;
        done_q  <= done_d;
        sent_q  <= sent_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mssc_result.sv @@
// mssc_result: limit registers, clamp decision, checksum patch and result register
// depends on mssc_pkg
`default_nettype none

module mssc_result (
  input  var logic                        clk_i,
  input  var logic                        rst_ni,
  input  var logic                        cfg_we_i,
  input  var logic                        cfg_idx_i,
  input  var logic [mssc_pkg::LimitW-1:0] cfg_data_i,
  input  var logic                        load_i,
  input  var mssc_pkg::seg_info_t         info_i,
  input  var logic                        is_ipv6_i,
  input  var logic [7:0]                  protocol_i,
  input  var logic                        out_ready_i,
  output logic                            out_valid_o,
  output logic                            rewrite_o,
  output logic [5:0]                      mss_offset_o,
  output logic [15:0]                     new_mss_o,
  output logic [15:0]                     old_mss_o,
  output logic [15:0]                     new_checksum_o
);

  logic [mssc_pkg::LimitW-1:0] v4_lim_q, v6_lim_q, limit;
  logic        rw;
  logic [17:0] sum0;
  logic [16:0] sum1;
  logic [16:0] sum2;
  logic [15:0] patched;
  logic        out_valid_q;
  logic        rw_q;
  logic [5:0]  off_q;
  logic [15:0] nm_q, om_q, nc_q;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_lim_q <= '0;
      v6_lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mssc_pkg::CfgIpv4Limit: v4_lim_q <= cfg_data_i;
        mssc_pkg::CfgIpv6Limit: v6_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp decision
  assign limit = is_ipv6_i ? v6_lim_q : v4_lim_q;
  assign rw = (protocol_i == mssc_pkg::ProtoTcp) && info_i.syn
              && ({1'b0, info_i.hdr_len} > mssc_pkg::HdrMinLen)
              && (info_i.mss != 16'd0) && (limit != '0)
              && (info_i.mss > {5'd0, limit});

  // incremental checksum update, one's complement sum folded twice
  assign sum0    = {2'b00, ~info_i.csum} + {2'b00, ~info_i.mss} + {7'd0, limit};
  assign sum1    = {1'b0, sum0[15:0]} + {15'd0, sum0[17:16]};
  assign sum2    = {1'b0, sum1[15:0]} + {16'd0, sum1[16]};
  assign patched = ~sum2[15:0];

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rw_q  <= rw;
      off_q <= info_i.mss_off;
      nm_q  <= rw ? {5'd0, limit} : info_i.mss;
      om_q  <= info_i.mss;
      nc_q  <= rw ? patched : info_i.csum;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rewrite_o      = rw_q;
  assign mss_offset_o   = off_q;
  assign new_mss_o      = nm_q;
  assign old_mss_o      = om_q;
  assign new_checksum_o = nc_q;

endmodule

`default_nettype wire

@@ rtl/tcp_mss_clamp.sv @@
// tcp_mss_clamp: top level, input register around the parser and result stage
// depends on mssc_pkg, mssc_walker, mssc_result
//
//   channel  | handshake              | word
//   ---------+------------------------+-------------------------------------------
//   in       | in_valid_i/in_ready_o  | data_byte, is_ipv6, protocol, last_byte
//   out      | out_valid_o/out_ready_i| rewrite, mss_offset, new_mss, old_mss,
//            |                        | new_checksum (one per segment)
//   cfg      | cfg_we_i               | cfg_idx_i, cfg_data_i, write only
//
// one input word per cycle unless the input is stalled; a word passes through the
// input register, and its result, if any, is then loaded into the result register.
// the parse step between the two registers is the only per-word logic.
// reset clears limits and segment state; no clearing pass.
// a full, unread result register stalls the input only when the word in the
// input register would produce another result.
`default_nettype none

module tcp_mss_clamp (
  input  var logic                        clk_i,
  input  var logic                        rst_ni,
  input  var logic                        cfg_we_i,
  input  var logic                        cfg_idx_i,
  input  var logic [mssc_pkg::LimitW-1:0] cfg_data_i,
  input  var logic                        in_valid_i,
  output logic                            in_ready_o,
  input  var logic [7:0]                  data_byte_i,
  input  var logic                        is_ipv6_i,
  input  var logic [7:0]                  protocol_i,
  input  var logic                        last_byte_i,
  output logic                            out_valid_o,
  input  var logic                        out_ready_i,
  output logic                            rewrite_o,
  output logic [5:0]                      mss_offset_o,
  output logic [15:0]                     new_mss_o,
  output logic [15:0]                     old_mss_o,
  output logic [15:0]                     new_checksum_o
);

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_v6_q;
  logic [7:0]  s1_proto_q;
  logic        s1_last_q;
  logic        s1_adv;
  logic        out_free;
  mssc_pkg::seg_info_t info;

  // advance when the word makes no result or the result slot frees up
  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_adv     = s1_valid_q && (!info.emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_v6_q    <= is_ipv6_i;
      s1_proto_q <= protocol_i;
      s1_last_q  <= last_byte_i;
    end
  end

  mssc_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .info_o      (info)
  );

  mssc_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .load_i         (s1_adv && info.emit),
    .info_i         (info),
    .is_ipv6_i      (s1_v6_q),
    .protocol_i     (s1_proto_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .rewrite_o      (rewrite_o),
    .mss_offset_o   (mss_offset_o),
    .new_mss_o      (new_mss_o),
    .old_mss_o      (old_mss_o),
    .new_checksum_o (new_checksum_o)
  );

endmodule

`default_nettype wire
